### src/asc_pkg.sv
// ---------------------------------------------------------------------------
// asc_pkg
// Shared types, codes and permutation helpers for the Ascon-128 encryptor.
// ---------------------------------------------------------------------------
package asc_pkg;

   typedef logic [63:0] word_type;
   typedef logic [3:0]  count_type;
   typedef logic [1:0]  kind_type;
   typedef logic [4:0][63:0] lanes_type;

   // request type codes
   localparam kind_type REQ_START = 2'd0;
   localparam kind_type REQ_AD    = 2'd1;
   localparam kind_type REQ_PT    = 2'd2;

   // result kind codes
   localparam kind_type KIND_CT     = 2'd0;
   localparam kind_type KIND_TAG_HI = 2'd1;
   localparam kind_type KIND_TAG_LO = 2'd2;

   // register indexes
   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;

   localparam word_type  ASCON_IV   = 64'h80400c0600000000;
   localparam count_type FULL_BYTES = 4'd8;
   localparam logic [3:0] LAST_ROUND  = 4'd11;
   localparam logic [3:0] ROUNDS_12   = 4'd0;
   localparam logic [3:0] ROUNDS_6    = 4'd6;

   // command queue geometry
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_INIT,
      PH_AD,
      PH_PT
   } phase_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_AD,
      CMD_SEP,
      CMD_PT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       pre_pad;
      logic       sep;
      logic       last;
      count_type  cnt;
      word_type   data;
      word_type   nonce_high;
      word_type   nonce_low;
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PERM,
      S_START_FIN,
      S_AD_MID,
      S_AD_FIN,
      S_PT_ABS,
      S_PT_PADK,
      S_TAG_HI,
      S_TAG_LO
   } core_state_type;

   function automatic word_type asc_rotr(word_type v, int unsigned n);
      return (v >> n) | (v << (64 - n));
   endfunction

   function automatic logic [7:0] asc_round_const(logic [3:0] idx);
      return 8'(8'hF0 - 8'd15 * {4'd0, idx});
   endfunction

   // top bytes kept, count 0..8
   function automatic word_type asc_byte_mask(count_type cnt);
      word_type m;
      m = '0;
      if (cnt != 4'd0) begin
         m = ~64'd0 << (7'd64 - {cnt, 3'b000});
      end
      return m;
   endfunction

   // single 0x80 byte right after the last valid byte, count 0..7
   function automatic word_type asc_pad_word(count_type cnt);
      return 64'h80 << (6'd56 - {cnt[2:0], 3'b000});
   endfunction

   // one permutation round
   function automatic lanes_type asc_round(lanes_type s, logic [3:0] idx);
      word_type x0, x1, x2, x3, x4;
      word_type t0, t1, t2, t3, t4;
      lanes_type r;
      x0 = s[0];
      x1 = s[1];
      x2 = s[2] ^ {56'd0, asc_round_const(idx)};
      x3 = s[3];
      x4 = s[4];
      // substitution layer
      x0 = x0 ^ x4;
      x4 = x4 ^ x3;
      x2 = x2 ^ x1;
      t0 = ~x0 & x1;
      t1 = ~x1 & x2;
      t2 = ~x2 & x3;
      t3 = ~x3 & x4;
      t4 = ~x4 & x0;
      x0 = x0 ^ t1;
      x1 = x1 ^ t2;
      x2 = x2 ^ t3;
      x3 = x3 ^ t4;
      x4 = x4 ^ t0;
      x1 = x1 ^ x0;
      x0 = x0 ^ x4;
      x3 = x3 ^ x2;
      x2 = ~x2;
      // linear diffusion layer
      r[0] = x0 ^ asc_rotr(x0, 19) ^ asc_rotr(x0, 28);
      r[1] = x1 ^ asc_rotr(x1, 61) ^ asc_rotr(x1, 39);
      r[2] = x2 ^ asc_rotr(x2, 1)  ^ asc_rotr(x2, 6);
      r[3] = x3 ^ asc_rotr(x3, 10) ^ asc_rotr(x3, 17);
      r[4] = x4 ^ asc_rotr(x4, 7)  ^ asc_rotr(x4, 41);
      return r;
   endfunction

endpackage

### src/asc_if.sv
// ---------------------------------------------------------------------------
// asc_if
// Valid/ready channels for request items and result items.
// ---------------------------------------------------------------------------
interface asc_req_if;
   logic                valid;
   logic                ready;
   asc_pkg::kind_type   req_type;
   asc_pkg::word_type   nonce_high;
   asc_pkg::word_type   nonce_low;
   asc_pkg::word_type   data_word;
   asc_pkg::count_type  byte_count;
   logic                last_block;

   modport source (output valid, req_type, nonce_high, nonce_low, data_word, byte_count,
                   last_block, input ready);
   modport sink (input valid, req_type, nonce_high, nonce_low, data_word, byte_count,
                 last_block, output ready);
endinterface

interface asc_rsp_if;
   logic                valid;
   logic                ready;
   asc_pkg::kind_type   out_kind;
   asc_pkg::word_type   out_data;
   asc_pkg::count_type  out_bytes;
   logic                out_last;

   modport source (output valid, out_kind, out_data, out_bytes, out_last, input ready);
   modport sink (input valid, out_kind, out_data, out_bytes, out_last, output ready);
endinterface

### src/asc_front.sv
// ---------------------------------------------------------------------------
// asc_front
// Accepts request items, tracks the message phase and turns each item into
// a command for the back end; items that have no effect are dropped.
// ---------------------------------------------------------------------------
module asc_front (
   input  logic              clock,
   input  logic              reset,
   asc_req_if.sink           req_chan,
   input  logic              q_full,
   output logic              push,
   output asc_pkg::cmd_type  push_cmd
);
   import asc_pkg::*;

   phase_type phase_ff, phase_in;
   count_type cnt_sat;
   logic      last;
   logic      accept;
   logic      want;

   // saturate count, short blocks count as last
   assign cnt_sat = (req_chan.byte_count > FULL_BYTES) ? FULL_BYTES : req_chan.byte_count;
   assign last    = req_chan.last_block | (cnt_sat < FULL_BYTES);

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid & req_chan.ready;
   assign push           = accept & want;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (req_chan.req_type)
            REQ_START: begin
               phase_in = PH_INIT;
            end
            REQ_AD: begin
               if (phase_ff inside {PH_INIT, PH_AD}) begin
                  phase_in = last ? PH_PT : PH_AD;
               end
            end
            REQ_PT: begin
               if (phase_ff != PH_IDLE) begin
                  phase_in = last ? PH_IDLE : PH_PT;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // command for the back end
   always_comb begin
      want                = 1'b0;
      push_cmd.op         = CMD_START;
      push_cmd.pre_pad    = 1'b0;
      push_cmd.sep        = 1'b0;
      push_cmd.last       = last;
      push_cmd.cnt        = cnt_sat;
      push_cmd.data       = req_chan.data_word;
      push_cmd.nonce_high = req_chan.nonce_high;
      push_cmd.nonce_low  = req_chan.nonce_low;
      case (req_chan.req_type)
         REQ_START: begin
            want = 1'b1;
         end
         REQ_AD: begin
            want = (phase_ff inside {PH_INIT, PH_AD});
            // empty associated data right after start only separates
            if (phase_ff == PH_INIT && last && cnt_sat == 4'd0) begin
               push_cmd.op = CMD_SEP;
            end else begin
               push_cmd.op = CMD_AD;
            end
         end
         REQ_PT: begin
            want             = (phase_ff != PH_IDLE);
            push_cmd.op      = CMD_PT;
            push_cmd.pre_pad = (phase_ff == PH_AD);
            push_cmd.sep     = (phase_ff == PH_INIT);
         end
         default: begin
            want = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

### src/asc_queue.sv
// ---------------------------------------------------------------------------
// asc_queue
// Short command queue between the front end and the back end.
// ---------------------------------------------------------------------------
module asc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  asc_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              q_valid,
   output asc_pkg::cmd_type  q_cmd
);
   import asc_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full    = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= (QUEUE_AW + 1)'(QUEUE_DEPTH)))
      else $error("command queue fill beyond depth");

endmodule

### src/asc_core.sv
// ---------------------------------------------------------------------------
// asc_core
// Back end: runs commands on the 320-bit state with one round per cycle and
// drives ciphertext and tag items through an output register.
// ---------------------------------------------------------------------------
module asc_core (
   input  logic              clock,
   input  logic              reset,
   input  asc_pkg::word_type key_high,
   input  asc_pkg::word_type key_low,
   input  logic              q_valid,
   input  asc_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   asc_rsp_if.source         rsp_chan
);
   import asc_pkg::*;

   core_state_type state_ff, state_in;
   core_state_type ret_ff, ret_in;
   lanes_type      lanes_ff, lanes_in;
   logic [3:0]     rnd_ff, rnd_in;
   cmd_type        cmd_ff, cmd_in;

   logic           rsp_valid_ff, rsp_valid_in;
   kind_type       out_kind_ff, out_kind_in;
   word_type       out_data_ff, out_data_in;
   count_type      out_bytes_ff, out_bytes_in;
   logic           out_last_ff, out_last_in;
   logic           out_load;

   logic           out_free;
   logic           pt_go;
   cmd_type        cur;
   word_type       cur_mask;
   word_type       cur_data;
   lanes_type      x;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign cur      = (state_ff == S_IDLE) ? q_cmd : cmd_ff;
   assign cur_mask = asc_byte_mask(cur.cnt);
   assign cur_data = cur.data & cur_mask;

   // plaintext absorb fires straight from idle, or after the closing pad block
   assign pt_go = out_free &&
      ((state_ff == S_IDLE && q_valid && q_cmd.op == CMD_PT && !q_cmd.pre_pad) ||
       (state_ff == S_PT_ABS));

   assign q_pop = (state_ff == S_IDLE) && q_valid &&
      !(q_cmd.op == CMD_PT && !q_cmd.pre_pad && !out_free);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               state_in = (q_cmd.op == CMD_SEP) ? S_IDLE : S_PERM;
            end
         end
         S_PERM: begin
            if (rnd_ff == LAST_ROUND) begin
               state_in = ret_ff;
            end
         end
         S_START_FIN: state_in = S_IDLE;
         S_AD_MID: begin
            state_in = (cmd_ff.cnt == FULL_BYTES) ? S_PERM : S_IDLE;
         end
         S_AD_FIN: state_in = S_IDLE;
         S_PT_ABS: begin
            if (out_free) begin
               state_in = S_PERM;
            end
         end
         S_PT_PADK: state_in = S_PERM;
         S_TAG_HI: begin
            if (out_free) begin
               state_in = S_TAG_LO;
            end
         end
         S_TAG_LO: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and result loading
   always_comb begin
      x            = lanes_ff;
      rnd_in       = rnd_ff;
      ret_in       = ret_ff;
      cmd_in       = cmd_ff;
      out_load     = 1'b0;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_bytes_in = out_bytes_ff;
      out_last_in  = out_last_ff;

      if (q_pop) begin
         cmd_in = q_cmd;
      end

      if (pt_go) begin
         // separation, absorb and ciphertext
         if (cur.pre_pad || cur.sep) begin
            x[4] = x[4] ^ 64'd1;
         end
         x[0]         = x[0] ^ cur_data;
         out_load     = 1'b1;
         out_kind_in  = KIND_CT;
         out_data_in  = x[0] & cur_mask;
         out_bytes_in = cur.cnt;
         out_last_in  = 1'b0;
         if (!cur.last) begin
            rnd_in = ROUNDS_6;
            ret_in = S_IDLE;
         end else if (cur.cnt == FULL_BYTES) begin
            rnd_in = ROUNDS_6;
            ret_in = S_PT_PADK;
         end else begin
            x[0]   = x[0] ^ asc_pad_word(cur.cnt);
            x[1]   = x[1] ^ key_high;
            x[2]   = x[2] ^ key_low;
            rnd_in = ROUNDS_12;
            ret_in = S_TAG_HI;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  case (q_cmd.op)
                     CMD_START: begin
                        x[0]   = ASCON_IV;
                        x[1]   = key_high;
                        x[2]   = key_low;
                        x[3]   = q_cmd.nonce_high;
                        x[4]   = q_cmd.nonce_low;
                        rnd_in = ROUNDS_12;
                        ret_in = S_START_FIN;
                     end
                     CMD_AD: begin
                        x[0] = x[0] ^ cur_data;
                        if (q_cmd.cnt < FULL_BYTES) begin
                           x[0] = x[0] ^ asc_pad_word(q_cmd.cnt);
                        end
                        rnd_in = ROUNDS_6;
                        ret_in = q_cmd.last ? S_AD_MID : S_IDLE;
                     end
                     CMD_SEP: begin
                        x[4] = x[4] ^ 64'd1;
                     end
                     CMD_PT: begin
                        // close open associated data with a padding block
                        x[0]   = x[0] ^ asc_pad_word(4'd0);
                        rnd_in = ROUNDS_6;
                        ret_in = S_PT_ABS;
                     end
                     default: begin
                        x = lanes_ff;
                     end
                  endcase
               end
            end
            S_PERM: begin
               x      = asc_round(lanes_ff, rnd_ff);
               rnd_in = rnd_ff + 4'd1;
            end
            S_START_FIN: begin
               x[3] = x[3] ^ key_high;
               x[4] = x[4] ^ key_low;
            end
            S_AD_MID: begin
               if (cmd_ff.cnt == FULL_BYTES) begin
                  x[0]   = x[0] ^ asc_pad_word(4'd0);
                  rnd_in = ROUNDS_6;
                  ret_in = S_AD_FIN;
               end else begin
                  x[4] = x[4] ^ 64'd1;
               end
            end
            S_AD_FIN: begin
               x[4] = x[4] ^ 64'd1;
            end
            S_PT_PADK: begin
               x[0]   = x[0] ^ asc_pad_word(4'd0);
               x[1]   = x[1] ^ key_high;
               x[2]   = x[2] ^ key_low;
               rnd_in = ROUNDS_12;
               ret_in = S_TAG_HI;
            end
            S_TAG_HI: begin
               if (out_free) begin
                  out_load     = 1'b1;
                  out_kind_in  = KIND_TAG_HI;
                  out_data_in  = lanes_ff[3] ^ key_high;
                  out_bytes_in = FULL_BYTES;
                  out_last_in  = 1'b0;
               end
            end
            S_TAG_LO: begin
               if (out_free) begin
                  out_load     = 1'b1;
                  out_kind_in  = KIND_TAG_LO;
                  out_data_in  = lanes_ff[4] ^ key_low;
                  out_bytes_in = FULL_BYTES;
                  out_last_in  = 1'b1;
               end
            end
            default: begin
               x = lanes_ff;
            end
         endcase
      end
      lanes_in     = x;
      rsp_valid_in = out_load | (rsp_valid_ff & !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rnd_ff       <= '0;
         lanes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rnd_ff       <= rnd_in;
         lanes_ff     <= lanes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command and result payload
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      out_kind_ff  <= out_kind_in;
      out_data_ff  <= out_data_in;
      out_bytes_ff <= out_bytes_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_kind  = out_kind_ff;
   assign rsp_chan.out_data  = out_data_ff;
   assign rsp_chan.out_bytes = out_bytes_ff;
   assign rsp_chan.out_last  = out_last_ff;

   a_tag_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAG_LO) |-> ($past(state_ff) == S_TAG_HI || $past(state_ff) == S_TAG_LO))
      else $error("tag low half without tag high half");

   a_perm_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PERM && state_in != S_PERM) |-> (rnd_ff == LAST_ROUND))
      else $error("permutation left before last round");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == S_PERM || state_ff == S_IDLE))
      else $error("command taken outside idle");

endmodule

### src/ascon128_aead_encrypt.sv
// ---------------------------------------------------------------------------
// ascon128_aead_encrypt
// Ascon-128 authenticated encryption, 64-bit rate, streaming blocks.
// ---------------------------------------------------------------------------
//  channel    dir  handshake        contents
//  req_chan   in   valid/ready      start with nonce, associated data, plaintext
//  rsp_chan   out  valid/ready      ciphertext block, tag high half, tag low half
//  csr_*      in   write enable     key_high (index 0), key_low (index 1)
//
// Sequencing: the back end runs one permutation round per cycle once a command
// has left the queue; a data block runs 6 rounds, a start 12 rounds and a key
// add; a final associated-data block adds a separation step, after a padding
// block of 6 rounds when it is full; a final plaintext block runs 12 rounds and
// sends both tag halves, and when it is full 6 rounds and a padding block come first.
// Reset: synchronous; clears key, phase, command queue, sequencer, output.
// Stalls: the front end keeps taking items while the two-entry command queue
// has room; the back end holds in its output states while rsp is not ready.
// ---------------------------------------------------------------------------
module ascon128_aead_encrypt (
   input  logic              clock,
   input  logic              reset,
   asc_req_if.sink           req_chan,
   asc_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  logic              csr_index,
   input  asc_pkg::word_type csr_wdata
);
   import asc_pkg::*;

   word_type key_high_ff, key_high_in;
   word_type key_low_ff, key_low_in;
   logic     push;
   cmd_type  push_cmd;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   cmd_type  q_cmd;

   // key registers
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_in = csr_wdata;
            CSR_KEY_LOW:  key_low_in  = csr_wdata;
            default:      key_high_in = key_high_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   asc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   asc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   asc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .key_high (key_high_ff),
      .key_low  (key_low_ff),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
